### sv/mmtrs_pkg.sv
// ----------------------------------------------------------------------------
// mmtrs_pkg
// Constants, types and helpers for the model matrix pipeline.
// ----------------------------------------------------------------------------
package mmtrs_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int TRIG_ITERATIONS = 16;
  localparam int ANGLE_W         = 19;
  localparam int TW              = 34;

  localparam logic signed [TW-1:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [TW-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [TW-1:0] Q30_GAIN    = 34'sd652032875;

  // clamp limit: round(pi * 2^FRAC_BITS)
  localparam longint ANGLE_LIM =
    (64'sd3373259426 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);

  typedef logic signed [TW-1:0] trig_t;
  typedef logic signed [31:0]   q_t;

  localparam trig_t ATAN_Q30 [10] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
    34'sd33543516, 34'sd16775851, 34'sd8388437, 34'sd4194283, 34'sd2097149
  };

  // cordic step angle atan(2^-i) in q30
  function automatic trig_t atan_step(input int i);
    if (i < 10) return ATAN_Q30[i];
    return trig_t'(34'sd1 <<< (30 - i));
  endfunction

  // round to nearest and drop 30 fraction bits
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v + (66'sd1 <<< 29)) >>> 30;
    return t[35:0];
  endfunction

  // product of two q30 trig terms back in q30
  function automatic q_t mul30(input q_t a, input q_t b);
    logic signed [35:0] r;
    r = rnd30(66'(a) * 66'(b));
    return r[31:0];
  endfunction

  // clip to the 32 bit signed range
  function automatic q_t sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

### sv/mmtrs_in_if.sv
// ----------------------------------------------------------------------------
// mmtrs_in_if
// Request channel: position, euler angles and scale of one entity.
// ----------------------------------------------------------------------------
interface mmtrs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [18:0] angle_x;
  logic signed [18:0] angle_y;
  logic signed [18:0] angle_z;
  logic signed [31:0] scale_x;
  logic signed [31:0] scale_y;
  logic signed [31:0] scale_z;

  modport source (output valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                  scale_x, scale_y, scale_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                scale_x, scale_y, scale_z, output ready);
endinterface

### sv/mmtrs_out_if.sv
// ----------------------------------------------------------------------------
// mmtrs_out_if
// Result channel: top three rows of the model matrix.
// ----------------------------------------------------------------------------
interface mmtrs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] m_r0c0, m_r0c1, m_r0c2, m_r0c3;
  logic signed [31:0] m_r1c0, m_r1c1, m_r1c2, m_r1c3;
  logic signed [31:0] m_r2c0, m_r2c1, m_r2c2, m_r2c3;

  modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r0c3, m_r1c0, m_r1c1,
                  m_r1c2, m_r1c3, m_r2c0, m_r2c1, m_r2c2, m_r2c3, input ready);
  modport sink (input valid, m_r0c0, m_r0c1, m_r0c2, m_r0c3, m_r1c0, m_r1c1,
                m_r1c2, m_r1c3, m_r2c0, m_r2c1, m_r2c2, m_r2c3, output ready);
endinterface

### sv/model_matrix_from_trs.sv
// ----------------------------------------------------------------------------
// model_matrix_from_trs
// Pipelined model matrix M = T * Rx * Ry * Rz * S in Q16.16.
// ----------------------------------------------------------------------------
// Usage: a request on item carries position, three euler angles (radians,
// clamped to +-pi) and per-axis scale. One result on result carries the top
// three rows of the 4x4 model matrix; the bottom row is always 0 0 0 1.
// Throughput: one request per cycle while result is not stalled. The pipeline
// holds a folded angle register, one cordic step per stage for all three
// angles in parallel, a quadrant sign stage, two trig product stages, a sum
// stage, a scale multiply and a saturation register.
// Stall: the whole pipeline advances together. While result is valid and not
// taken, every stage holds and item.ready is low; nothing is lost or repeated.
// Reset: rst clears all stage valid bits; no request is in flight afterward.
// ----------------------------------------------------------------------------
module model_matrix_from_trs
  import mmtrs_pkg::*;
(
  input logic         clk,
  input logic         rst,
  mmtrs_in_if.sink    item,
  mmtrs_out_if.source result
);

  localparam int N = TRIG_ITERATIONS;

  logic en;
  logic out_valid;

  // pipeline advances when the output register is free or being taken
  assign en         = !out_valid || result.ready;
  assign item.ready = en;

  // angle clamp and quadrant fold
  logic signed [ANGLE_W-1:0] ang [3];
  trig_t                     z_in [3];
  logic                      neg_in [3];

  assign ang[0] = item.angle_x;
  assign ang[1] = item.angle_y;
  assign ang[2] = item.angle_z;

  always_comb begin
    trig_t a;
    for (int k = 0; k < 3; k++) begin
      a = TW'(ang[k]);
      if (a > trig_t'(ANGLE_LIM)) a = trig_t'(ANGLE_LIM);
      if (a < -trig_t'(ANGLE_LIM)) a = -trig_t'(ANGLE_LIM);
      a = a <<< (30 - FRAC_BITS);
      neg_in[k] = 1'b0;
      if (a > Q30_HALF_PI) begin
        a = a - Q30_PI;
        neg_in[k] = 1'b1;
      end else if (a < -Q30_HALF_PI) begin
        a = a + Q30_PI;
        neg_in[k] = 1'b1;
      end
      z_in[k] = a;
    end
  end

  // cordic stage registers, index 0 is the folded angle
  logic        vld_c [0:N];
  trig_t       cx_q  [0:N][3];
  trig_t       cy_q  [0:N][3];
  trig_t       cz_q  [0:N][3];
  logic        neg_q [0:N][3];
  logic [95:0] pos_q [0:N];
  logic [95:0] scl_q [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c[0] <= 1'b0;
    end else if (en) begin
      vld_c[0] <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cx_q[0][k]  <= Q30_GAIN;
        cy_q[0][k]  <= '0;
        cz_q[0][k]  <= z_in[k];
        neg_q[0][k] <= neg_in[k];
      end
      pos_q[0] <= {item.pos_z, item.pos_y, item.pos_x};
      scl_q[0] <= {item.scale_z, item.scale_y, item.scale_x};
    end
  end

  // one cordic rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_c[i+1] <= 1'b0;
      end else if (en) begin
        vld_c[i+1] <= vld_c[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          if (cz_q[i][k] >= 0) begin
            cx_q[i+1][k] <= cx_q[i][k] - (cy_q[i][k] >>> i);
            cy_q[i+1][k] <= cy_q[i][k] + (cx_q[i][k] >>> i);
            cz_q[i+1][k] <= cz_q[i][k] - atan_step(i);
          end else begin
            cx_q[i+1][k] <= cx_q[i][k] + (cy_q[i][k] >>> i);
            cy_q[i+1][k] <= cy_q[i][k] - (cx_q[i][k] >>> i);
            cz_q[i+1][k] <= cz_q[i][k] + atan_step(i);
          end
          neg_q[i+1][k] <= neg_q[i][k];
        end
        pos_q[i+1] <= pos_q[i];
        scl_q[i+1] <= scl_q[i];
      end
    end
  end

  // sine and cosine with quadrant sign
  logic        vld_t;
  q_t          sin_t [3];
  q_t          cos_t [3];
  logic [95:0] pos_t, scl_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_t <= 1'b0;
    end else if (en) begin
      vld_t <= vld_c[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sin_t[k] <= neg_q[N][k] ? q_t'(-cy_q[N][k]) : q_t'(cy_q[N][k]);
        cos_t[k] <= neg_q[N][k] ? q_t'(-cx_q[N][k]) : q_t'(cx_q[N][k]);
      end
      pos_t <= pos_q[N];
      scl_t <= scl_q[N];
    end
  end

  // pairwise trig products
  logic        vld_p1;
  q_t          cycz1, cysz1, sy1, cxsz1, cxcz1, sxcy1, sxsz1, sxcz1, cxcy1;
  q_t          sxsy1, cxsy1, cz1, sz1;
  logic [95:0] pos_p1, scl_p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p1 <= 1'b0;
    end else if (en) begin
      vld_p1 <= vld_t;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cycz1  <= mul30(cos_t[1], cos_t[2]);
      cysz1  <= mul30(cos_t[1], sin_t[2]);
      sy1    <= sin_t[1];
      cxsz1  <= mul30(cos_t[0], sin_t[2]);
      cxcz1  <= mul30(cos_t[0], cos_t[2]);
      sxcy1  <= mul30(sin_t[0], cos_t[1]);
      sxsz1  <= mul30(sin_t[0], sin_t[2]);
      sxcz1  <= mul30(sin_t[0], cos_t[2]);
      cxcy1  <= mul30(cos_t[0], cos_t[1]);
      sxsy1  <= mul30(sin_t[0], sin_t[1]);
      cxsy1  <= mul30(cos_t[0], sin_t[1]);
      cz1    <= cos_t[2];
      sz1    <= sin_t[2];
      pos_p1 <= pos_t;
      scl_p1 <= scl_t;
    end
  end

  // triple products
  logic        vld_p2;
  q_t          cycz2, cysz2, sy2, cxsz2, cxcz2, sxcy2, sxsz2, sxcz2, cxcy2;
  q_t          sxsycz2, sxsysz2, cxsycz2, cxsysz2;
  logic [95:0] pos_p2, scl_p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p2 <= 1'b0;
    end else if (en) begin
      vld_p2 <= vld_p1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cycz2   <= cycz1;
      cysz2   <= cysz1;
      sy2     <= sy1;
      cxsz2   <= cxsz1;
      cxcz2   <= cxcz1;
      sxcy2   <= sxcy1;
      sxsz2   <= sxsz1;
      sxcz2   <= sxcz1;
      cxcy2   <= cxcy1;
      sxsycz2 <= mul30(sxsy1, cz1);
      sxsysz2 <= mul30(sxsy1, sz1);
      cxsycz2 <= mul30(cxsy1, cz1);
      cxsysz2 <= mul30(cxsy1, sz1);
      pos_p2  <= pos_p1;
      scl_p2  <= scl_p1;
    end
  end

  // rotation coefficients, row major
  logic               vld_p3;
  logic signed [32:0] rc3 [9];
  logic [95:0]        pos_p3, scl_p3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p3 <= 1'b0;
    end else if (en) begin
      vld_p3 <= vld_p2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rc3[0] <= 33'(cycz2);
      rc3[1] <= -33'(cysz2);
      rc3[2] <= 33'(sy2);
      rc3[3] <= 33'(cxsz2) + 33'(sxsycz2);
      rc3[4] <= 33'(cxcz2) - 33'(sxsysz2);
      rc3[5] <= -33'(sxcy2);
      rc3[6] <= 33'(sxsz2) - 33'(cxsycz2);
      rc3[7] <= 33'(sxcz2) + 33'(cxsysz2);
      rc3[8] <= 33'(cxcy2);
      pos_p3 <= pos_p2;
      scl_p3 <= scl_p2;
    end
  end

  // scale each column
  logic               vld_p4;
  logic signed [35:0] sc4 [9];
  logic [95:0]        pos_p4;
  q_t                 kcol [3];

  assign kcol[0] = scl_p3[31:0];
  assign kcol[1] = scl_p3[63:32];
  assign kcol[2] = scl_p3[95:64];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p4 <= 1'b0;
    end else if (en) begin
      vld_p4 <= vld_p3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        sc4[k] <= rnd30(66'(rc3[k]) * 66'(kcol[k % 3]));
      end
      pos_p4 <= pos_p3;
    end
  end

  // saturate into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_p4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.m_r0c0 <= sat32(sc4[0]);
      result.m_r0c1 <= sat32(sc4[1]);
      result.m_r0c2 <= sat32(sc4[2]);
      result.m_r0c3 <= pos_p4[31:0];
      result.m_r1c0 <= sat32(sc4[3]);
      result.m_r1c1 <= sat32(sc4[4]);
      result.m_r1c2 <= sat32(sc4[5]);
      result.m_r1c3 <= pos_p4[63:32];
      result.m_r2c0 <= sat32(sc4[6]);
      result.m_r2c1 <= sat32(sc4[7]);
      result.m_r2c2 <= sat32(sc4[8]);
      result.m_r2c3 <= pos_p4[95:64];
    end
  end

  assign result.valid = out_valid;

  // folded angles stay within a quarter turn
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    vld_c[0] |-> (cz_q[0][0] <= Q30_HALF_PI && cz_q[0][0] >= -Q30_HALF_PI &&
                  cz_q[0][1] <= Q30_HALF_PI && cz_q[0][1] >= -Q30_HALF_PI &&
                  cz_q[0][2] <= Q30_HALF_PI && cz_q[0][2] >= -Q30_HALF_PI))
    else $error("folded angle out of range");

  // a new result comes only from the scale stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld_p4))
    else $error("result valid without a request in the last stage");

  // a stall freezes the pipeline
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(vld_p4) && $stable(vld_t)))
    else $error("pipeline moved during a stall");

endmodule

### dv/tb_model_matrix_from_trs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_model_matrix_from_trs
// Checks the model matrix pipeline against an independent fixed-point
// predictor: cordic sine/cosine, q30 products, scaling and saturation.
// Directed corner requests come first, then random ones, with random gaps
// on both channels and one long result stall that backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_model_matrix_from_trs;
  import mmtrs_pkg::*;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [18:0] ang [3];
    logic signed [31:0] scl [3];
  } xform_t;

  typedef struct {
    logic signed [31:0] m [12];
  } matrix_t;

  logic clk;
  logic rst;

  mmtrs_in_if  item ();
  mmtrs_out_if result ();

  model_matrix_from_trs DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source)
  );

  xform_t  pending_xforms [$];
  matrix_t expected_matrices [$];
  int      mismatch_count;
  int      results_seen;
  int      gap_left;
  int      stall_left;
  int      long_stall_cycles;
  bit      long_stall_done;

  // q30 helpers of the predictor
  function automatic longint q30_round(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return q30_round(a * b);
  endfunction

  function automatic logic signed [31:0] scale_clip(longint r, longint k);
    longint v;
    v = q30_round(r * k);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // cordic sine and cosine of a q3.16 angle, q30 results
  function automatic void cordic_sin_cos(input logic signed [18:0] a, output longint s,
                                         output longint c);
    longint lim, z, x, y, stp, dx, dy, ang;
    bit flip;
    lim = (64'sd3373259426 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    ang = a;
    if (ang > lim) ang = lim;
    if (ang < -lim) ang = -lim;
    z = ang <<< (30 - FRAC_BITS);
    x = 652032875;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z = z - 64'sd3373259426;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z = z + 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < TRIG_ITERATIONS; i++) begin
      stp = (i < 10) ? longint'(ATAN_Q30[i]) : (64'sd1 <<< (30 - i));
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - stp;
      end else begin
        x = x + dx; y = y - dy; z = z + stp;
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // expected matrix rows for one transform
  function automatic matrix_t predict_matrix(xform_t t);
    matrix_t r;
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy, kx, ky, kz;
    cordic_sin_cos(t.ang[0], sx, cx);
    cordic_sin_cos(t.ang[1], sy, cy);
    cordic_sin_cos(t.ang[2], sz, cz);
    kx = t.scl[0]; ky = t.scl[1]; kz = t.scl[2];
    sxsy = q30_mul(sx, sy);
    cxsy = q30_mul(cx, sy);
    r.m[0]  = scale_clip(q30_mul(cy, cz), kx);
    r.m[1]  = scale_clip(-q30_mul(cy, sz), ky);
    r.m[2]  = scale_clip(sy, kz);
    r.m[3]  = t.pos[0];
    r.m[4]  = scale_clip(q30_mul(cx, sz) + q30_mul(sxsy, cz), kx);
    r.m[5]  = scale_clip(q30_mul(cx, cz) - q30_mul(sxsy, sz), ky);
    r.m[6]  = scale_clip(-q30_mul(sx, cy), kz);
    r.m[7]  = t.pos[1];
    r.m[8]  = scale_clip(q30_mul(sx, sz) - q30_mul(cxsy, cz), kx);
    r.m[9]  = scale_clip(q30_mul(sx, cz) + q30_mul(cxsy, sz), ky);
    r.m[10] = scale_clip(q30_mul(cx, cy), kz);
    r.m[11] = t.pos[2];
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic logic signed [18:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 19'sd205887;
      1: return -19'sd205887;
      2: return 19'($urandom);
      default: return 19'($signed($urandom_range(0, 411774)) - 205887);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
      2: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h800000)) - 32'sh400000;
    endcase
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // limit
  initial begin
    #4ms;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
      gap_left <= 0;
    end else if (!item.valid || item.ready) begin
      if (gap_left > 0 || pending_xforms.size() == 0) begin
        item.valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        xform_t t;
        t = pending_xforms.pop_front();
        expected_matrices.push_back(predict_matrix(t));
        item.valid   <= 1'b1;
        item.pos_x   <= t.pos[0];
        item.pos_y   <= t.pos[1];
        item.pos_z   <= t.pos[2];
        item.angle_x <= t.ang[0];
        item.angle_y <= t.ang[1];
        item.angle_z <= t.ang[2];
        item.scale_x <= t.scl[0];
        item.scale_y <= t.scl[1];
        item.scale_z <= t.scl[2];
        gap_left <= gap_len();
      end
    end
  end

  // result stall: random gaps, with one long hold-off after 40 results
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      stall_left <= 0;
      long_stall_cycles <= 0;
      long_stall_done <= 0;
    end else if (!long_stall_done && results_seen >= 40) begin
      result.ready <= 1'b0;
      long_stall_cycles <= long_stall_cycles + 1;
      if (long_stall_cycles >= 80) long_stall_done <= 1;
    end else if (stall_left > 0) begin
      result.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      result.ready <= 1'b1;
      stall_left <= gap_len();
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      logic signed [31:0] got [12];
      matrix_t want;
      got = '{result.m_r0c0, result.m_r0c1, result.m_r0c2, result.m_r0c3,
              result.m_r1c0, result.m_r1c1, result.m_r1c2, result.m_r1c3,
              result.m_r2c0, result.m_r2c1, result.m_r2c2, result.m_r2c3};
      results_seen <= results_seen + 1;
      if (expected_matrices.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = expected_matrices.pop_front();
        for (int i = 0; i < 12; i++) begin
          if (got[i] !== want.m[i]) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
              $display("result %0d r%0dc%0d: expected %0d got %0d", results_seen,
                       i / 4, i % 4, want.m[i], got[i]);
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    xform_t t;
    int waited;
    mismatch_count = 0;
    results_seen = 0;
    rst = 1'b1;
    item.valid = 1'b0;
    item.pos_x = '0; item.pos_y = '0; item.pos_z = '0;
    item.angle_x = '0; item.angle_y = '0; item.angle_z = '0;
    item.scale_x = '0; item.scale_y = '0; item.scale_z = '0;
    result.ready = 1'b0;
    // directed: identity, angle limits, beyond pi, saturating scales
    for (int d = 0; d < 20; d++) begin
      for (int a = 0; a < 3; a++) begin
        t.pos[a] = (d % 3 == 0) ? 32'sh7fffffff : (d % 3 == 1) ? 32'sh80000000 : d * 1000;
        t.scl[a] = 32'sh10000;
        t.ang[a] = '0;
      end
      case (d)
        1: t.ang = '{19'sd205887, 19'sd205887, 19'sd205887};
        2: t.ang = '{-19'sd205887, -19'sd205887, -19'sd205887};
        3: t.ang = '{19'sh3ffff, -19'sh40000, 19'sd205888};
        4: t.ang = '{19'sd102943, 19'sd102944, -19'sd102944};
        5: t.scl = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
        6: t.scl = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
        7: t.scl = '{32'sh0, 32'shffffffff, 32'sh1};
        default: begin
          if (d >= 8) begin
            for (int a = 0; a < 3; a++) begin
              t.ang[a] = rand_angle();
              t.scl[a] = (d & 1) ? 32'sh7fffffff : 32'sh80000000;
            end
          end
        end
      endcase
      pending_xforms.push_back(t);
    end
    for (int n = 0; n < 450; n++) begin
      for (int a = 0; a < 3; a++) begin
        t.pos[a] = $urandom;
        t.ang[a] = rand_angle();
        t.scl[a] = rand_scale();
      end
      pending_xforms.push_back(t);
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_xforms.size() != 0 || expected_matrices.size() != 0)
      @(posedge clk);
    waited = 0;
    while (waited < 60) begin
      @(posedge clk);
      waited++;
    end
    $display("run covered %0d matrices: angle limits, beyond-pi clamp, saturating scales,",
             results_seen);
    $display("random gaps on both channels and one %0d-cycle result stall",
             long_stall_cycles);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/mmtrs_pkg.sv
sv/mmtrs_in_if.sv
sv/mmtrs_out_if.sv
sv/model_matrix_from_trs.sv
dv/tb_model_matrix_from_trs.sv
